// ===== src/afdcp_pkg.sv =====
package afdcp_pkg;

  // Message length limit and the byte counter that can hold it
  localparam int MaxMessage = 256;
  localparam int CountW     = $clog2(MaxMessage + 1);

  localparam int ByteW   = 8;
  localparam int WinLen  = 6;
  localparam int LenW    = 3;
  localparam int ValW    = 23;
  localparam int DigitW  = 9;

  localparam logic [LenW-1:0] LenMax = 3'd7;

  localparam logic [ByteW-1:0] ChEquals = 8'h3D;
  localparam logic [ByteW-1:0] ChBang   = 8'h21;
  localparam logic [ByteW-1:0] ChMinus  = 8'h2D;
  localparam logic signed [DigitW-1:0] DigitBase = 9'sd48;

  localparam logic [15:0] KeyReset = 16'h5331;

  // Index 0 holds the newest character
  typedef logic [WinLen-1:0][ByteW-1:0] window_t;

  typedef struct packed {
    window_t         win;
    logic [LenW-1:0] len;
    logic            neg;
  } field_t;

endpackage

// ===== src/afdcp_value.sv =====
module afdcp_value import afdcp_pkg::*; (
  input  field_t                 field,
  output logic signed [ValW-1:0] value,
  output logic                   len_ok
);

  logic signed [DigitW-1:0] d1, d2, d4, d5, d6;
  logic signed [ValW-1:0]   e1, e2, e4, e5, e6;
  logic signed [ValW-1:0]   mag;

  // Character third from the end is the point and never enters the sum
  assign d1 = $signed({1'b0, field.win[0]}) - DigitBase;
  assign d2 = $signed({1'b0, field.win[1]}) - DigitBase;
  assign d4 = $signed({1'b0, field.win[3]}) - DigitBase;
  assign d5 = $signed({1'b0, field.win[4]}) - DigitBase;
  assign d6 = $signed({1'b0, field.win[5]}) - DigitBase;

  assign e1 = ValW'(d1);
  assign e2 = ValW'(d2);
  assign e4 = ValW'(d4);
  assign e5 = ValW'(d5);
  assign e6 = ValW'(d6);

  always_comb begin
    mag    = '0;
    len_ok = 1'b0;
    unique case (field.len)
      3'd4: begin
        mag    = e4 * 23'sd100 + e2 * 23'sd10 + e1;
        len_ok = 1'b1;
      end
      3'd5: begin
        mag    = e5 * 23'sd1000 + e4 * 23'sd100 + e2 * 23'sd10 + e1;
        len_ok = 1'b1;
      end
      3'd6: begin
        mag    = e6 * 23'sd10000 + e5 * 23'sd1000 + e4 * 23'sd100 + e2 * 23'sd10 + e1;
        len_ok = 1'b1;
      end
      default: begin
        mag    = '0;
        len_ok = 1'b0;
      end
    endcase
  end

  assign value = field.neg ? -mag : mag;

endmodule

// ===== src/ascii_fixed_decimal_command_parser_unit.sv =====
// Tuning-message parser: one message byte per request, result on '!'.
// A '!' request passes the input register and then the result register; the two decouple sides.
// Throughput: one byte per cycle while results are being taken.
// Reset (rst_n low, synchronous): field and key state cleared, key_word to "S1",
// both pipeline valids dropped.
module ascii_fixed_decimal_command_parser_unit import afdcp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration
  input  logic                   cfg_we,
  input  logic [15:0]            cfg_wdata,
  // byte requests
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ByteW-1:0]       in_byte_in,
  input  logic                   in_first,
  // results
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [ValW-1:0] out_value_hundredths,
  output logic                   out_key_matches,
  output logic                   out_length_ok
);

  logic [15:0] key_word_r;

  // Input register stage
  logic             in_vld_r;
  logic [ByteW-1:0] byte_r;
  logic             first_r;

  // Parser state
  field_t            field_r, field_nxt;
  logic              after_eq_r, after_eq_nxt;
  logic [1:0]        key_pos_r, key_pos_nxt;
  logic              key_ok_r, key_ok_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic              fin_r, fin_nxt;

  // State as seen once a first marker has been applied
  field_t            field_c;
  logic              after_eq_c;
  logic [1:0]        key_pos_c;
  logic              key_ok_c;
  logic [CountW-1:0] count_c;
  logic              fin_c;

  logic              advance;
  logic              proc;
  logic              emit;
  logic [ByteW-1:0]  key_byte;

  logic signed [ValW-1:0] value;
  logic                   len_ok;

  // Result register
  logic                   out_vld_r;
  logic signed [ValW-1:0] out_val_r;
  logic                   out_key_r;
  logic                   out_len_r;

  // Advance the byte stage whenever the result slot is free or being emptied
  assign advance  = !out_vld_r || out_ready;
  assign in_ready = !in_vld_r || advance;
  assign proc     = in_vld_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_word_r <= KeyReset;
    end else if (cfg_we) begin
      key_word_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r  <= in_byte_in;
      first_r <= in_first;
    end
  end

  // First marker: clear the message and mark the field start
  always_comb begin
    field_c    = field_r;
    after_eq_c = after_eq_r;
    key_pos_c  = key_pos_r;
    key_ok_c   = key_ok_r;
    count_c    = count_r;
    fin_c      = fin_r;
    if (first_r) begin
      field_c    = '0;
      after_eq_c = 1'b1;
      key_pos_c  = 2'd0;
      key_ok_c   = 1'b1;
      count_c    = '0;
      fin_c      = 1'b0;
    end
  end

  assign key_byte = (key_pos_c == 2'd0) ? key_word_r[15:8] : key_word_r[7:0];

  // Byte handling: key check, terminator, field restart, sign, shift in
  always_comb begin
    field_nxt    = field_c;
    after_eq_nxt = after_eq_c;
    key_pos_nxt  = key_pos_c;
    key_ok_nxt   = key_ok_c;
    count_nxt    = count_c;
    fin_nxt      = fin_c;
    emit         = 1'b0;
    if (!fin_c && (count_c < CountW'(MaxMessage))) begin
      count_nxt = count_c + 1'b1;
      if (key_pos_c < 2'd2) begin
        if (byte_r != key_byte) begin
          key_ok_nxt = 1'b0;
        end
        key_pos_nxt = key_pos_c + 1'b1;
      end
      if (byte_r == ChBang) begin
        emit    = 1'b1;
        fin_nxt = 1'b1;
      end else if (byte_r == ChEquals) begin
        field_nxt    = '0;
        after_eq_nxt = 1'b1;
      end else if (after_eq_c && (byte_r == ChMinus)) begin
        field_nxt.neg = 1'b1;
        after_eq_nxt  = 1'b0;
      end else begin
        after_eq_nxt  = 1'b0;
        field_nxt.win = {field_c.win[WinLen-2:0], byte_r};
        if (field_c.len != LenMax) begin
          field_nxt.len = field_c.len + 1'b1;
        end
      end
    end
  end

  afdcp_value u_value (
    .field  (field_c),
    .value  (value),
    .len_ok (len_ok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r    <= '0;
      after_eq_r <= 1'b0;
      key_pos_r  <= 2'd0;
      key_ok_r   <= 1'b1;
      count_r    <= '0;
      fin_r      <= 1'b0;
    end else if (proc) begin
      field_r    <= field_nxt;
      after_eq_r <= after_eq_nxt;
      key_pos_r  <= key_pos_nxt;
      key_ok_r   <= key_ok_nxt;
      count_r    <= count_nxt;
      fin_r      <= fin_nxt;
    end
  end

  // Hold the result until taken; load a new one only on a terminator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= proc && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      out_val_r <= value;
      out_key_r <= key_ok_nxt && (key_pos_nxt == 2'd2);
      out_len_r <= len_ok;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_value_hundredths = out_val_r;
  assign out_key_matches      = out_key_r;
  assign out_length_ok        = out_len_r;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top import afdcp_pkg::*;;

  // Bytes that the message builder needs beyond the ones the package names
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChPoint = 8'h2E;

  localparam int RandomItems = 1600;
  localparam int DrainCycles = 8;    // settling time after the last result is back
  localparam int LongHold    = 400;  // long enough for the block to back up to its input

  typedef enum int {
    MsgTuning,
    MsgRepeatEq,
    MsgNoise,
    MsgHeadless
  } msg_kind_t;

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic                   key_match;
    logic                   len_ok;
  } tuning_result_t;

  // Tracks the parser state request by request and holds the parsed values still owed
  class tuning_checker;
    logic [15:0]      key_word;
    logic [ByteW-1:0] window [WinLen];  // index 0 is the newest character
    int               field_len;
    int               key_pos;
    int               byte_count;
    int               failures;
    bit               negative;
    bit               after_equals;
    bit               key_ok;
    bit               finished;
    tuning_result_t   owed_q[$];

    function new();
      failures     = 0;
      key_word     = KeyReset;
      key_pos      = 0;
      key_ok       = 1'b1;
      byte_count   = 0;
      finished     = 1'b0;
      after_equals = 1'b0;
      clear_field();
    endfunction

    function void clear_field();
      foreach (window[i]) window[i] = '0;
      field_len = 0;
      negative  = 1'b0;
    endfunction

    // Digits are taken as byte minus the digit base, unchecked; the point is skipped
    function int field_value();
      int d [WinLen];
      int v;
      foreach (d[i]) d[i] = int'(window[i]) - int'(DigitBase);
      case (field_len)
        4: v = d[3] * 100 + d[1] * 10 + d[0];
        5: v = d[4] * 1000 + d[3] * 100 + d[1] * 10 + d[0];
        6: v = d[5] * 10000 + d[4] * 1000 + d[3] * 100 + d[1] * 10 + d[0];
        default: v = 0;
      endcase
      return negative ? -v : v;
    endfunction

    // Returns 1 if the byte was parsed, 0 if the block drops it
    function bit take_byte(logic [ByteW-1:0] b, logic f);
      tuning_result_t r;
      logic [ByteW-1:0] key_byte;
      int v;
      if (f) begin
        clear_field();
        after_equals = 1'b1;
        key_pos      = 0;
        key_ok       = 1'b1;
        byte_count   = 0;
        finished     = 1'b0;
      end
      if (finished || byte_count >= MaxMessage) return 1'b0;
      byte_count++;
      if (key_pos < 2) begin
        key_byte = (key_pos == 0) ? key_word[15:8] : key_word[7:0];
        if (b != key_byte) key_ok = 1'b0;
        key_pos++;
      end
      if (b == ChBang) begin
        v           = field_value();
        r.value     = v[ValW-1:0];
        r.key_match = key_ok && key_pos == 2;
        r.len_ok    = field_len >= 4 && field_len <= 6;
        owed_q.push_back(r);
        finished = 1'b1;
      end else if (b == ChEquals) begin
        clear_field();
        after_equals = 1'b1;
      end else if (after_equals && b == ChMinus) begin
        negative     = 1'b1;
        after_equals = 1'b0;
      end else begin
        after_equals = 1'b0;
        for (int i = WinLen - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = b;
        if (field_len < 7) field_len++;
      end
      return 1'b1;
    endfunction

    function void check_value(logic signed [ValW-1:0] value, logic key_match, logic len_ok);
      tuning_result_t e;
      if (owed_q.size() == 0) begin
        $error("result with no request owing it: value_hundredths %0d", value);
        failures++;
        return;
      end
      e = owed_q.pop_front();
      if (value !== e.value) begin
        $error("value_hundredths: expected %0d, got %0d", e.value, value);
        failures++;
      end
      if (key_match !== e.key_match) begin
        $error("key_matches: expected %0b, got %0b", e.key_match, key_match);
        failures++;
      end
      if (len_ok !== e.len_ok) begin
        $error("length_ok: expected %0b, got %0b", e.len_ok, len_ok);
        failures++;
      end
    endfunction

    function int owed();
      return owed_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [15:0]            cfg_wdata;
  logic                   in_valid;
  logic                   in_ready;
  logic [ByteW-1:0]       in_byte_in;
  logic                   in_first;
  logic                   out_valid;
  logic                   out_ready;
  logic signed [ValW-1:0] out_value_hundredths;
  logic                   out_key_matches;
  logic                   out_length_ok;

  tuning_checker chk;
  int            items_taken   = 0;
  bit            long_hold_due = 1'b0;
  bit            sender_burst  = 1'b0;

  ascii_fixed_decimal_command_parser_unit u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_byte_in           (in_byte_in),
    .in_first             (in_first),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_value_hundredths (out_value_hundredths),
    .out_key_matches      (out_key_matches),
    .out_length_ok        (out_length_ok)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic msg_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return MsgTuning;
    if (r < 72) return MsgRepeatEq;
    if (r < 88) return MsgNoise;
    return MsgHeadless;
  endfunction

  // A field character: nearly always a digit, occasionally any byte at all
  function automatic logic [ByteW-1:0] field_char();
    if ($urandom_range(0, 19) == 0) return 8'($urandom);
    return ChZero + 8'($urandom_range(0, 9));
  endfunction

  // Offer one request after an optional gap and hold it until the block takes it.
  // Valid is only lowered when a gap follows, so back-to-back requests keep it high.
  task automatic send_byte(logic [ByteW-1:0] b, logic f);
    int gap;
    gap = sender_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte_in <= b;
    in_first   <= f;
    do @(posedge clk); while (!in_ready);
    void'(chk.take_byte(b, f));
    items_taken++;
  endtask

  task automatic send_text(string s, bit marked);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], marked && i == 0);
  endtask

  // Build one message of the given kind and send it request by request
  task automatic send_message(msg_kind_t kind);
    logic [ByteW-1:0] body[$];
    logic [ByteW-1:0] k_hi;
    logic [ByteW-1:0] k_lo;
    int n;
    int len;
    int r;
    bit with_first;
    with_first   = (kind == MsgNoise) ? ($urandom_range(0, 4) != 0) : (kind != MsgHeadless);
    sender_burst = ($urandom_range(0, 6) == 0);
    if (kind == MsgNoise) begin
      n = $urandom_range(1, 20);
      repeat (n) body.push_back(8'($urandom));
      if ($urandom_range(0, 2) == 0) body[$urandom_range(0, n - 1)] = ChBang;
    end else begin
      if (kind != MsgHeadless) begin
        // usually the configured key, sometimes one or both bytes spoilt
        k_hi = chk.key_word[15:8];
        k_lo = chk.key_word[7:0];
        r    = $urandom_range(0, 9);
        if (r == 0) k_hi = 8'($urandom);
        if (r == 1) k_lo = 8'($urandom);
        body.push_back(k_hi);
        body.push_back(k_lo);
      end
      if (kind == MsgRepeatEq) begin
        // an abandoned field, which the second equals must wipe
        body.push_back(ChEquals);
        if ($urandom_range(0, 1)) body.push_back(ChMinus);
        repeat ($urandom_range(0, 3)) body.push_back(field_char());
      end
      body.push_back(ChEquals);
      if ($urandom_range(0, 1)) body.push_back(ChMinus);
      len = ($urandom_range(0, 9) < 7) ? $urandom_range(4, 6) : $urandom_range(0, 9);
      for (int j = 0; j < len; j++) begin
        body.push_back((j == len - 3 && $urandom_range(0, 19) != 0) ? ChPoint : field_char());
      end
      body.push_back(ChBang);
      // trailing bytes after the end mark are dropped by the block
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 4)) body.push_back(8'($urandom));
    end
    foreach (body[i]) begin
      send_byte(body[i], (with_first && i == 0) ||
                         (kind == MsgNoise && $urandom_range(0, 19) == 0));
    end
  endtask

  // A message that runs to the length limit; the end mark lands at byte bang_at
  task automatic send_long(int bang_at);
    logic [ByteW-1:0] b;
    sender_burst = 1'b0;
    for (int i = 0; i <= bang_at; i++) begin
      b = 8'($urandom);
      if (b == ChBang) b = ChZero;
      send_byte((i == bang_at) ? ChBang : b, i == 0);
    end
  endtask

  // Hold off the sender until every owed result is back
  task automatic pause_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (chk.owed() != 0);
  endtask

  // Settle the block fully before touching the key register
  task automatic drain_results();
    pause_for_results();
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_key(logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    chk.key_word  = value;
  endtask

  // Result side: check each accepted result, stall at random, and take the one
  // long hold-off when the stimulus asks for it.
  initial begin : result_sink
    int stall_left;
    int burst_left;
    stall_left = 0;
    burst_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        chk.check_value(out_value_hundredths, out_key_matches, out_length_ok);
      end
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        stall_left    = LongHold;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else if ($urandom_range(0, 99) == 0) begin
          burst_left = $urandom_range(40, 150);
        end else if ($urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  initial begin : stimulus
    logic [15:0] phase_key;
    int target;
    bit paused;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_byte_in <= '0;
    in_first   <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    chk = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests under the reset key
    send_text("-9.99!", 1'b0);       // no start marker yet: the minus counts as a character
    send_text("S1=-123.45!", 1'b1);  // key match, leading minus, longest field
    send_text("!", 1'b1);            // end mark as the very first byte
    send_text("S!", 1'b1);           // end mark in the second key position
    send_text("=-!", 1'b1);          // minus with no digits behind it

    // Random messages over several key settings, the extremes among them
    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        drain_results();
        case (phase)
          1: phase_key = 16'h0000;
          2: phase_key = 16'hFFFF;
          3: phase_key = 16'($urandom);
          4: phase_key = {8'($urandom_range(33, 126)), 8'($urandom_range(33, 126))};
          default: phase_key = KeyReset;
        endcase
        write_key(phase_key);
      end
      // let the results back up into the input while bytes keep coming
      if (phase == 1) long_hold_due = 1'b1;
      if (phase == 0) send_long(MaxMessage - 1);
      if (phase == 3) send_long(MaxMessage + $urandom_range(0, 20));
      target = RandomItems * (phase + 1) / 6;
      paused = 1'b0;
      while (items_taken < target) begin
        if (phase == 2 && !paused && items_taken >= target - RandomItems / 12) begin
          pause_for_results();
          paused = 1'b1;
        end
        send_message(pick_kind());
      end
    end

    drain_results();
    if (chk.failures == 0 && chk.owed() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== ascii_fixed_decimal_command_parser_unit.f =====
src/afdcp_pkg.sv
src/afdcp_value.sv
src/ascii_fixed_decimal_command_parser_unit.sv
tb/tb_top.sv
